// ===== rtl/tba_pkg.sv =====
// ----------------------------------------------------------------------------
// tba_pkg
// Shared types and constants of the trimmed block average unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tba_pkg;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam int REG_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECIM_PERIOD = 1'b1;

  localparam logic [REG_W-1:0] WINDOW_SIZE_RST  = 8'd3;
  localparam logic [REG_W-1:0] DECIM_PERIOD_RST = 8'd1;

  // Smallest window that still leaves one sample after trimming
  localparam logic [REG_W-1:0] MIN_WINDOW = 8'd3;
  localparam logic [REG_W-1:0] TRIM_COUNT = 8'd2;

  // Window queue between accumulator and divider
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_HOLD
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/tba_front.sv =====
// ----------------------------------------------------------------------------
// tba_front
// Decimates samples, accumulates sum, max and min, and queues each window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tba_front #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [SAMPLE_WIDTH-1:0]      in_sample,
  input  wire logic [tba_pkg::REG_W-1:0]    window_size,
  input  wire logic [tba_pkg::REG_W-1:0]    decim_period,
  input  wire tba_pkg::queue_stat_t         q_stat,
  output logic                              push,
  output logic [SAMPLE_WIDTH+tba_pkg::REG_W+SAMPLE_WIDTH+SAMPLE_WIDTH+tba_pkg::REG_W-1:0]
                                            push_data
);

  localparam int CNT_W = tba_pkg::REG_W;
  localparam int SUM_W = SAMPLE_WIDTH + CNT_W;

  logic [CNT_W-1:0]        tick_r, tick_nxt;
  logic [CNT_W-1:0]        kept_r, kept_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SAMPLE_WIDTH-1:0] max_r, max_nxt;
  logic [SAMPLE_WIDTH-1:0] min_r, min_nxt;

  logic                    accept;
  logic                    keep;
  logic                    done;
  logic [CNT_W-1:0]        tick_inc;
  logic [CNT_W-1:0]        kept_inc;
  logic [CNT_W-1:0]        limit;
  logic [SUM_W-1:0]        sum_add;
  logic [SAMPLE_WIDTH-1:0] max_upd;
  logic [SAMPLE_WIDTH-1:0] min_upd;

  // Stall whenever the queue has no room for a finished window
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign tick_inc = tick_r + 1'b1;
  assign keep     = !(tick_inc < decim_period);
  assign kept_inc = kept_r + 1'b1;
  assign sum_add  = sum_r + {{CNT_W{1'b0}}, in_sample};
  assign max_upd  = (in_sample > max_r) ? in_sample : max_r;
  assign min_upd  = (in_sample < min_r) ? in_sample : min_r;
  assign limit    = (window_size < tba_pkg::MIN_WINDOW) ? tba_pkg::MIN_WINDOW : window_size;
  assign done     = !(kept_inc < limit);

  always_comb begin
    tick_nxt = tick_r;
    kept_nxt = kept_r;
    sum_nxt  = sum_r;
    max_nxt  = max_r;
    min_nxt  = min_r;
    push     = 1'b0;
    if (accept) begin
      tick_nxt = keep ? '0 : tick_inc;
      if (keep) begin
        if (done) begin
          // hand the window off and start a fresh one
          push     = 1'b1;
          kept_nxt = '0;
          sum_nxt  = '0;
          max_nxt  = '0;
          min_nxt  = '1;
        end else begin
          kept_nxt = kept_inc;
          sum_nxt  = sum_add;
          max_nxt  = max_upd;
          min_nxt  = min_upd;
        end
      end
    end
  end

  assign push_data = {sum_add, max_upd, min_upd, kept_inc - tba_pkg::TRIM_COUNT};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      kept_r <= '0;
      sum_r  <= '0;
      max_r  <= '0;
      min_r  <= '1;
    end else begin
      tick_r <= tick_nxt;
      kept_r <= kept_nxt;
      sum_r  <= sum_nxt;
      max_r  <= max_nxt;
      min_r  <= min_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tba_queue.sv =====
// ----------------------------------------------------------------------------
// tba_queue
// Short first-in first-out queue of finished windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tba_queue #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output tba_pkg::queue_stat_t  q_stat
);

  localparam int DEPTH = tba_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tba_back.sv =====
// ----------------------------------------------------------------------------
// tba_back
// Trims each queued window and divides it, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tba_back #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tba_pkg::queue_stat_t    q_stat,
  input  wire logic [SAMPLE_WIDTH+tba_pkg::REG_W+SAMPLE_WIDTH+SAMPLE_WIDTH+tba_pkg::REG_W-1:0]
                                       pop_data,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [SAMPLE_WIDTH-1:0]      out_average
);

  localparam int DIV_W  = tba_pkg::REG_W;
  localparam int SUM_W  = SAMPLE_WIDTH + DIV_W;
  localparam int STEP_W = $clog2(SUM_W);

  // queue entry layout: sum, max, min, divisor
  localparam int DIV_LO = 0;
  localparam int MIN_LO = DIV_LO + DIV_W;
  localparam int MAX_LO = MIN_LO + SAMPLE_WIDTH;
  localparam int SUM_LO = MAX_LO + SAMPLE_WIDTH;

  tba_pkg::back_state_t state_r, state_nxt;

  logic [DIV_W-1:0]        rem_r, rem_nxt;
  logic [SUM_W-1:0]        quo_r, quo_nxt;
  logic [DIV_W-1:0]        div_r, div_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_avg_r, out_avg_nxt;

  logic [SUM_W-1:0]        q_sum;
  logic [SUM_W-1:0]        q_max;
  logic [SUM_W-1:0]        q_min;
  logic [DIV_W:0]          rem_sh;
  logic [DIV_W:0]          rem_sub;
  logic                    ge;
  logic                    out_free;

  assign q_sum = pop_data[SUM_LO +: SUM_W];
  assign q_max = {{DIV_W{1'b0}}, pop_data[MAX_LO +: SAMPLE_WIDTH]};
  assign q_min = {{DIV_W{1'b0}}, pop_data[MIN_LO +: SAMPLE_WIDTH]};

  // restoring division step: dividend bits shift out the top of quo_r
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign ge      = (rem_sh >= {1'b0, div_r});

  assign out_free    = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    div_nxt       = div_r;
    step_nxt      = step_r;
    out_avg_nxt   = out_avg_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;
    unique case (state_r)
      tba_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          quo_nxt   = q_sum - q_max - q_min;
          div_nxt   = pop_data[DIV_LO +: DIV_W];
          rem_nxt   = '0;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = tba_pkg::B_DIV;
        end
      end
      tba_pkg::B_DIV: begin
        rem_nxt  = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_nxt  = {quo_r[SUM_W-2:0], ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = tba_pkg::B_HOLD;
        end
      end
      tba_pkg::B_HOLD: begin
        if (out_free) begin
          out_avg_nxt   = quo_r[SAMPLE_WIDTH-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = tba_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = tba_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tba_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    div_r     <= div_nxt;
    step_r    <= step_nxt;
    out_avg_r <= out_avg_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/trimmed_block_average_unit.sv =====
// ---- trimmed_block_average_unit: block mean with max and min removed ----
// Path: the last kept item's window is queued, divided and registered onto out_valid.
// Throughput: one item per cycle while the queue has room; each window holds the
// divider until its result loads, so short windows stall in_ once two windows wait.
// Reset: synchronous, active low; clears counters, sums, queue and output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trimmed_block_average_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // sample channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [SAMPLE_WIDTH-1:0]          in_sample,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [SAMPLE_WIDTH-1:0]               out_average,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [tba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tba_pkg::REG_W-1:0]        cfg_wdata
);

  // Queue entry: window sum, max, min and divisor (kept count minus two)
  localparam int ENTRY_W = SAMPLE_WIDTH + tba_pkg::REG_W + SAMPLE_WIDTH + SAMPLE_WIDTH
                           + tba_pkg::REG_W;

  logic [tba_pkg::REG_W-1:0] window_size_r, window_size_nxt;
  logic [tba_pkg::REG_W-1:0] decim_period_r, decim_period_nxt;

  tba_pkg::queue_stat_t q_stat;
  logic                 push;
  logic                 pop;
  logic [ENTRY_W-1:0]   push_data;
  logic [ENTRY_W-1:0]   pop_data;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must land only while the unit is idle,
  // which the user must keep to; the block does not enforce it and applies
  // them immediately; a shrunk window or period acts at the next kept item.
  // --------------------------------------------------------------------------
  always_comb begin
    window_size_nxt  = window_size_r;
    decim_period_nxt = decim_period_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tba_pkg::CFG_WINDOW_SIZE:  window_size_nxt  = cfg_wdata;
        tba_pkg::CFG_DECIM_PERIOD: decim_period_nxt = cfg_wdata;
        default: begin
          window_size_nxt  = window_size_r;
          decim_period_nxt = decim_period_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r  <= tba_pkg::WINDOW_SIZE_RST;
      decim_period_r <= tba_pkg::DECIM_PERIOD_RST;
    end else begin
      window_size_r  <= window_size_nxt;
      decim_period_r <= decim_period_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Front: decimate, accumulate sum/max/min, and push the finished window
  // into the queue. Stall only when the queue is full.
  // --------------------------------------------------------------------------
  tba_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .window_size  (window_size_r),
    .decim_period (decim_period_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // --------------------------------------------------------------------------
  // Two-entry queue: lets the next window accumulate while the divider works.
  // --------------------------------------------------------------------------
  tba_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // --------------------------------------------------------------------------
  // Back: trim (sum - max - min), divide by kept count minus two with a
  // bit-serial restoring divider (SAMPLE_WIDTH+8 steps), then load the
  // output register. The output register frees the divider for the next
  // window while a result waits on out_stall.
  // --------------------------------------------------------------------------
  tba_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .pop_data    (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_average (out_average)
  );

`ifndef ASSERT_OFF
  // queue cannot be full and empty at once
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // divider pops only an occupied queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a pushed window leaves the queue non-empty
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_stat.empty)
    else $error("pushed window lost");

  // a finished window is only pushed while the front accepts an item
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_valid && !in_stall))
    else $error("window pushed without an accepted item");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for trimmed_block_average_unit
// Sends samples through the valid/stall input channel and predicts every
// trimmed window mean in a cycle-free software copy of the block. The copy
// covers decimation and window bookkeeping. Each accepted output is checked
// in order. Directed windows cover the sample extremes, the window floor,
// and window and decimation changes made in the middle of a count. Random
// phases then vary both registers, the sample mix and the idle and stall
// patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int SW            = 16;
  localparam int IDLE_PCT      = 24;
  // Divider and output path plus a margin; let this pass before a register write
  localparam int SETTLE_CYCLES = SW + 24;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int MAX_REPORTS   = 40;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic [SW-1:0]                 in_sample  = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [SW-1:0]                 out_average;
  logic                          cfg_we     = 1'b0;
  logic [tba_pkg::CFG_IDX_W-1:0] cfg_index  = tba_pkg::CFG_WINDOW_SIZE;
  logic [tba_pkg::REG_W-1:0]     cfg_wdata  = '0;

  // Software copy of the block: registers and window state
  logic [tba_pkg::REG_W-1:0] window_size_reg;
  logic [tba_pkg::REG_W-1:0] decim_reg;
  logic [7:0]       tick_cnt;
  logic [7:0]       kept_cnt;
  logic [SW+7:0]    window_sum;
  logic [SW-1:0]    window_hi;
  logic [SW-1:0]    window_lo;

  logic [SW-1:0] expected_averages[$];
  logic [SW-1:0] next_average;

  // Hold both sides free of idling while this is set
  bit steady_flow = 1'b0;

  int error_count     = 0;
  int samples_sent    = 0;
  int averages_seen   = 0;
  int reg_writes      = 0;
  int quiet_cycles    = 0;

  trimmed_block_average_unit #(
    .SAMPLE_WIDTH(SW)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_average(out_average),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  task automatic clear_window_state();
    kept_cnt   = '0;
    window_sum = '0;
    window_hi  = '0;
    window_lo  = '1;
  endtask

  // Advance the window state by one tick; return 1 when a window closes
  function automatic bit predict_trimmed_mean(input logic [SW-1:0] value,
                                              output logic [SW-1:0] average);
    logic [tba_pkg::REG_W-1:0] limit;
    logic [SW+7:0]    trimmed;
    average  = '0;
    tick_cnt = tick_cnt + 8'd1;
    // Drop ticks until the decimation count is reached; 0 and 1 keep all
    if (tick_cnt < decim_reg) return 1'b0;
    tick_cnt   = '0;
    kept_cnt   = kept_cnt + 8'd1;
    window_sum = window_sum + (SW+8)'(value);
    if (value > window_hi) window_hi = value;
    if (value < window_lo) window_lo = value;
    // Windows below the floor behave as the floor size
    limit = (window_size_reg < tba_pkg::MIN_WINDOW) ? tba_pkg::MIN_WINDOW : window_size_reg;
    // A shrunk window closes at the first kept sample past its new size
    if (kept_cnt < limit) return 1'b0;
    trimmed = window_sum - (SW+8)'(window_hi) - (SW+8)'(window_lo);
    average = SW'(trimmed / ((SW+8)'(kept_cnt) - (SW+8)'(tba_pkg::TRIM_COUNT)));
    window_sum = '0;
    kept_cnt   = '0;
    window_hi  = '0;
    window_lo  = '1;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Shared stimulus tasks
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Offer one item, idling now and then, and hold it until accepted
  task automatic send_sample(input logic [SW-1:0] value);
    logic [SW-1:0] average;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (predict_trimmed_mean(value, average)) expected_averages.push_back(average);
  endtask

  // Stop sending, wait for every pending average, then let the block settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller has drained the block first
  task automatic write_reg(input logic [tba_pkg::CFG_IDX_W-1:0] index,
                           input logic [tba_pkg::REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (index == tba_pkg::CFG_WINDOW_SIZE) window_size_reg = value;
    else                                   decim_reg       = value;
    reg_writes++;
    // keep back-to-back writes apart with cfg_we held low
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [tba_pkg::REG_W-1:0] window_size,
                             input logic [tba_pkg::REG_W-1:0] decim);
    drain_and_settle();
    write_reg(tba_pkg::CFG_WINDOW_SIZE, window_size);
    write_reg(tba_pkg::CFG_DECIM_PERIOD, decim);
  endtask

  // Mix extremes and narrow bands (ties for max and min) into uniform samples
  function automatic logic [SW-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return SW'($urandom_range(0, 15));
      3:       return '1 - SW'($urandom_range(0, 15));
      default: return SW'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: window of three, no decimation
  task automatic test_reset_windows();
    send_sample(16'h0000); send_sample(16'h0000); send_sample(16'h0000);
    send_sample(16'hFFFF); send_sample(16'hFFFF); send_sample(16'hFFFF);
    send_sample(16'h0000); send_sample(16'hFFFF); send_sample(16'h1234);
  endtask

  // Window sizes below three fall back to three
  task automatic test_window_floor();
    reconfigure(8'd0, 8'd0);
    send_sample(16'hAAAA); send_sample(16'h5555); send_sample(16'hFFFF);
    reconfigure(8'd2, 8'd1);
    send_sample(16'h0001); send_sample(16'h8000); send_sample(16'h7FFF);
  endtask

  // Shrink the window below the kept count; the next kept sample closes it
  task automatic test_window_shrink();
    reconfigure(8'd8, 8'd1);
    send_sample(16'h0100); send_sample(16'hF000);
    send_sample(16'h0003); send_sample(16'h4000);
    drain_and_settle();
    write_reg(tba_pkg::CFG_WINDOW_SIZE, 8'd3);
    send_sample(16'h2222);
  endtask

  // Shrink the decimation below the tick count; the next tick is kept
  task automatic test_decim_shrink();
    reconfigure(8'd3, 8'd6);
    send_sample(16'h1111); send_sample(16'h2222); send_sample(16'h3333);
    drain_and_settle();
    write_reg(tba_pkg::CFG_DECIM_PERIOD, 8'd2);
    send_sample(16'h0F0F);
    drain_and_settle();
    write_reg(tba_pkg::CFG_DECIM_PERIOD, 8'd0);
    send_sample(16'hFFFE); send_sample(16'h0002);
  endtask

  // Longest decimation: one kept tick in 255, then finish the window undecimated
  task automatic test_max_decimation();
    reconfigure(8'd3, 8'd255);
    repeat (255) send_sample(random_sample());
    drain_and_settle();
    write_reg(tba_pkg::CFG_DECIM_PERIOD, 8'd0);
    repeat (2) send_sample(random_sample());
  endtask

  // Random phases; one holds the largest window, three run without idling
  task automatic test_random_phases();
    logic [tba_pkg::REG_W-1:0] window_size;
    logic [tba_pkg::REG_W-1:0] decim;
    int               count;
    for (int phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 9))
        0:       window_size = tba_pkg::REG_W'($urandom_range(0, 2));
        1:       window_size = tba_pkg::REG_W'($urandom_range(13, 40));
        default: window_size = tba_pkg::REG_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: decim = tba_pkg::REG_W'($urandom_range(0, 1));
        5, 6, 7, 8:    decim = tba_pkg::REG_W'($urandom_range(2, 4));
        default:       decim = tba_pkg::REG_W'($urandom_range(5, 8));
      endcase
      count = $urandom_range(50, 90);
      if (phase == 4) begin
        window_size = 8'd255;
        decim       = 8'd1;
        count       = 300;
      end
      // Leave a partial window open across most register changes
      reconfigure(window_size, decim);
      steady_flow = (phase >= 1 && phase <= 3);
      repeat (count) send_sample(random_sample());
      steady_flow = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking, output stall and watchdog
  // --------------------------------------------------------------------------

  // Compare each accepted average with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_averages.size() == 0) begin
        report_mismatch($sformatf("average %0d with none pending", out_average));
      end else begin
        next_average = expected_averages.pop_front();
        averages_seen++;
        if (out_average !== next_average)
          report_mismatch($sformatf("average got %0d want %0d",
                                    out_average, next_average));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // End the run after a long stretch with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
          $display("watchdog: no progress in %0d cycles, %0d averages pending",
                   quiet_cycles, expected_averages.size());
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    window_size_reg = tba_pkg::WINDOW_SIZE_RST;
    decim_reg       = tba_pkg::DECIM_PERIOD_RST;
    tick_cnt        = '0;
    clear_window_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_windows();
    test_window_floor();
    test_window_shrink();
    test_decim_shrink();
    test_random_phases();
    test_max_decimation();

    // Let the last averages out, then wait out the pipeline
    drain_and_settle();
    if (expected_averages.size() != 0)
      report_mismatch($sformatf("%0d averages never arrived", expected_averages.size()));

    $display("Covered %0d samples, %0d trimmed averages, %0d register writes,",
             samples_sent, averages_seen, reg_writes);
    $display("windows 0 to 255, decimation 0 to 255, random idle and stall; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
